// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker module of the encoder.
// Needs nothing else; the checker includes it by file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge while reset is released.
`define UPE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("upe: assertion failed");

// Property checked on every rising edge, reset included.
`define UPE_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("upe: reset assertion failed");

`endif

// ===== hdl/upe_pkg.sv =====
// Constants, escape masks and helper functions for the URL percent encoder.
// No dependencies; imported by url_percent_encoder.
`default_nettype none

package upe_pkg;

    localparam int unsigned ADDR_W = 3;
    localparam int unsigned DATA_W = 32;

    localparam logic [7:0] PERCENT_CHAR = 8'h25;

    localparam logic [1:0] PH_PCT = 2'd0;
    localparam logic [1:0] PH_HI  = 2'd1;
    localparam logic [1:0] PH_LO  = 2'd2;

    localparam logic [0:0] REG_ESCAPE_SET = 1'b0;

    localparam logic [2:0] SET_URI       = 3'd0;
    localparam logic [2:0] SET_ARGS      = 3'd1;
    localparam logic [2:0] SET_COMPONENT = 3'd2;
    localparam logic [2:0] SET_HTML      = 3'd3;
    localparam logic [2:0] SET_REFRESH   = 3'd4;

    localparam logic [255:0] MASK_URI = {
        {4{32'hffffffff}}, 32'h80000000, 32'h00000000, 32'h80000029, 32'hffffffff};
    localparam logic [255:0] MASK_ARGS = {
        {4{32'hffffffff}}, 32'h80000000, 32'h00000000, 32'h88000869, 32'hffffffff};
    localparam logic [255:0] MASK_COMPONENT = {
        {4{32'hffffffff}}, 32'hb8000001, 32'h78000001, 32'hfc009fff, 32'hffffffff};
    localparam logic [255:0] MASK_HTML = {
        {4{32'hffffffff}}, 32'h80000000, 32'h00000000, 32'h000000ad, 32'hffffffff};
    localparam logic [255:0] MASK_REFRESH = {
        {4{32'hffffffff}}, 32'h80000000, 32'h00000000, 32'h00000085, 32'hffffffff};
    localparam logic [255:0] MASK_MEMCACHED = {
        {4{32'h00000000}}, 32'h00000000, 32'h00000000, 32'h00000021, 32'hffffffff};

    function automatic logic f_needs_escape(input logic [2:0] set, input logic [7:0] b);
        logic [255:0] mask;
        unique case (set)
            SET_URI:       mask = MASK_URI;
            SET_ARGS:      mask = MASK_ARGS;
            SET_COMPONENT: mask = MASK_COMPONENT;
            SET_HTML:      mask = MASK_HTML;
            SET_REFRESH:   mask = MASK_REFRESH;
            default:       mask = MASK_MEMCACHED;
        endcase
        return mask[b];
    endfunction

    function automatic logic [7:0] f_hex(input logic [3:0] nib);
        logic [7:0] d;
        if (nib < 4'd10) begin
            d = 8'h30 + {4'd0, nib};
        end else begin
            d = 8'h37 + {4'd0, nib};
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/url_percent_encoder.sv =====
// URL percent encoder: one input stage, one result register, APB escape-set register.
// Depends on upe_pkg for masks, hex digits and phase codes.
//
// Channel   Direction  Payload
// s_axis    in         tdata = in_byte, tlast = last_in
// m_axis    out        tdata = out_byte, tlast = last_out
// apb       in/out     escape_set at byte address 0
//
// A literal byte yields one output byte, an escaped byte three, with at most one output byte
// per cycle; a new input byte is taken as the last output byte of the current one is registered.
// An accepted byte passes the input stage and then the result register on its way to m_axis.
// Reset is synchronous and active low; it empties both stages and clears escape_set.
// A stalled output holds the result register and the input stage; a full input
// stage then refuses new items.
`default_nettype none

module url_percent_encoder
    import upe_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [7:0]        s_axis_tdata,   // [7:0] in_byte
    input  wire logic              s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [7:0]             m_axis_tdata,   // [7:0] out_byte
    output logic                   m_axis_tlast,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    logic [2:0] r_set;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic [1:0] r_phase;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic       esc;
    logic       advance;
    logic       final_byte;
    logic       in_take;
    logic [7:0] n_out_byte;
    logic [1:0] n_phase;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ESCAPE_SET) ? {{(DATA_W-3){1'b0}}, r_set} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set <= '0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_ESCAPE_SET) begin
            r_set <= pwdata[2:0];
        end
    end

    assign esc        = f_needs_escape(r_set, r_in_byte);
    assign advance    = r_in_valid && (!r_out_valid || m_axis_tready);
    assign final_byte = !esc || r_phase == PH_LO;
    assign s_axis_tready = !r_in_valid || (advance && final_byte);
    assign in_take    = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_out_byte = r_in_byte;
        n_phase    = PH_PCT;
        if (esc) begin
            unique case (r_phase)
                PH_PCT: begin
                    n_out_byte = PERCENT_CHAR;
                    n_phase    = PH_HI;
                end
                PH_HI: begin
                    n_out_byte = f_hex(r_in_byte[7:4]);
                    n_phase    = PH_LO;
                end
                PH_LO: begin
                    n_out_byte = f_hex(r_in_byte[3:0]);
                    n_phase    = PH_PCT;
                end
                default: begin
                    n_out_byte = PERCENT_CHAR;
                    n_phase    = PH_PCT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= PH_PCT;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance && final_byte) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_phase <= n_phase;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte <= n_out_byte;
            r_out_last <= r_in_last && final_byte;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

// ===== hdl/upe_checker.sv =====
// Port-level assertions for url_percent_encoder, attached by a bind statement.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module upe_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              s_axis_tvalid,
    input wire logic              s_axis_tready,
    input wire logic              m_axis_tvalid,
    input wire logic              m_axis_tready,
    input wire logic [7:0]        m_axis_tdata,
    input wire logic              m_axis_tlast,
    input wire logic              psel,
    input wire logic              pready
);

    logic s_take;
    logic m_stall;

    assign s_take  = s_axis_tvalid && s_axis_tready;
    assign m_stall = m_axis_tvalid && !m_axis_tready;

    // An accepted item is always followed by a valid result on the output.
    `UPE_ASSERT(a_take_to_out, i_clk, i_rst_n, s_take |-> ##2 m_axis_tvalid)

    // A stalled result keeps its byte and last flag.
    `UPE_ASSERT(a_out_hold, i_clk, i_rst_n, m_stall |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))

    // Reset empties the result register and frees the input side.
    `UPE_ASSERT_ALWAYS(a_rst_out, i_clk, !i_rst_n |=> !m_axis_tvalid)
    `UPE_ASSERT_ALWAYS(a_rst_in, i_clk, !i_rst_n |=> s_axis_tready)

    // The configuration port never waits.
    `UPE_ASSERT(a_pready, i_clk, i_rst_n, psel |-> pready)

endmodule

bind url_percent_encoder upe_checker u_upe_checker (.*);

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for url_percent_encoder: a directed table, then random strings
// under changing idle patterns, each output byte checked against typed bytes or a bench encoder model.
// Depends on upe_pkg for the port widths, the register index and the escape-set codes.
module testbench;
    import upe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned LONG_HOLD = 80;
    localparam int unsigned MAX_REPORTS = 10;
    localparam logic [ADDR_W-1:0] ESCAPE_SET_ADDR = ADDR_W'(4 * REG_ESCAPE_SET);

    localparam logic [2:0] SET_MEMCACHED = 3'd5;
    localparam logic [2:0] SET_MAIL_AUTH = 3'd6;
    localparam logic [2:0] SET_UNUSED = 3'd7;

    localparam logic [0:15][7:0] HEX_DIGITS = "0123456789ABCDEF";

    // Word w of a set covers bytes 32*w to 32*w+31, byte b at bit b%32.
    localparam logic [0:7][0:7][31:0] ESCAPE_WORDS = '{
        '{32'hffffffff, 32'h80000029, 32'h00000000, 32'h80000000,
          32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff},
        '{32'hffffffff, 32'h88000869, 32'h00000000, 32'h80000000,
          32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff},
        '{32'hffffffff, 32'hfc009fff, 32'h78000001, 32'hb8000001,
          32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff},
        '{32'hffffffff, 32'h000000ad, 32'h00000000, 32'h80000000,
          32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff},
        '{32'hffffffff, 32'h00000085, 32'h00000000, 32'h80000000,
          32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff},
        '{32'hffffffff, 32'h00000021, 32'h00000000, 32'h00000000,
          32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000},
        '{32'hffffffff, 32'h00000021, 32'h00000000, 32'h00000000,
          32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000},
        '{32'hffffffff, 32'h00000021, 32'h00000000, 32'h00000000,
          32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000}
    };

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } enc_byte_t;

    // fixed_bytes holds up to three typed-in output bytes, the first in the top byte;
    // n_fixed of zero leaves the row to the encoder model.
    typedef struct packed {
        logic [2:0]  set;
        logic [7:0]  data;
        logic        last;
        logic [1:0]  n_fixed;
        logic [23:0] fixed_bytes;
    } stim_row_t;

    localparam int unsigned N_DIRECTED = 24;
    localparam stim_row_t [0:N_DIRECTED-1] DIRECTED = '{
        '{SET_URI,       8'h00, 1'b0, 2'd3, 24'h253030},
        '{SET_URI,       8'h1f, 1'b0, 2'd3, 24'h253146},
        '{SET_URI,       8'h41, 1'b0, 2'd1, 24'h410000},
        '{SET_URI,       8'h7f, 1'b0, 2'd3, 24'h253746},
        '{SET_URI,       8'h80, 1'b0, 2'd3, 24'h253830},
        '{SET_URI,       8'hff, 1'b1, 2'd3, 24'h254646},
        '{SET_ARGS,      8'h26, 1'b0, 2'd0, 24'h000000},
        '{SET_ARGS,      8'h3d, 1'b0, 2'd0, 24'h000000},
        '{SET_ARGS,      8'h20, 1'b1, 2'd0, 24'h000000},
        '{SET_COMPONENT, 8'h2f, 1'b0, 2'd0, 24'h000000},
        '{SET_COMPONENT, 8'h7e, 1'b0, 2'd0, 24'h000000},
        '{SET_COMPONENT, 8'h5f, 1'b1, 2'd0, 24'h000000},
        '{SET_HTML,      8'h3c, 1'b0, 2'd0, 24'h000000},
        '{SET_HTML,      8'h22, 1'b1, 2'd0, 24'h000000},
        '{SET_REFRESH,   8'h22, 1'b0, 2'd0, 24'h000000},
        '{SET_REFRESH,   8'h21, 1'b1, 2'd0, 24'h000000},
        '{SET_MEMCACHED, 8'hff, 1'b0, 2'd1, 24'hff0000},
        '{SET_MEMCACHED, 8'h20, 1'b0, 2'd3, 24'h253230},
        '{SET_MEMCACHED, 8'h7f, 1'b0, 2'd1, 24'h7f0000},
        '{SET_MEMCACHED, 8'h80, 1'b1, 2'd1, 24'h800000},
        '{SET_MAIL_AUTH, 8'h25, 1'b0, 2'd3, 24'h253235},
        '{SET_MAIL_AUTH, 8'hff, 1'b1, 2'd1, 24'hff0000},
        '{SET_UNUSED,    8'h00, 1'b0, 2'd3, 24'h253030},
        '{SET_UNUSED,    8'hff, 1'b1, 2'd1, 24'hff0000}
    };

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata = '0;   // [7:0] in_byte
    logic              s_axis_tlast = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [7:0]        m_axis_tdata;        // [7:0] out_byte
    logic              m_axis_tlast;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    enc_byte_t   expected_bytes[$];
    logic [2:0]  escape_set_model = SET_URI;
    int unsigned tx_idle_pct = 31;
    int unsigned rx_idle_pct = 60;
    int unsigned hold_requests = 0;
    int unsigned holds_served = 0;
    int unsigned hold_left = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    url_percent_encoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("url_percent_encoder: mismatch");
            $finish;
        end
    end

    function automatic logic byte_is_escaped(input logic [2:0] set, input logic [7:0] b);
        return ESCAPE_WORDS[set][b[7:5]][b[4:0]];
    endfunction

    task automatic predict_encoding(input logic [7:0] b, input logic last);
        if (byte_is_escaped(escape_set_model, b)) begin
            expected_bytes.push_back('{PERCENT_CHAR, 1'b0});
            expected_bytes.push_back('{HEX_DIGITS[b[7:4]], 1'b0});
            expected_bytes.push_back('{HEX_DIGITS[b[3:0]], last});
        end else begin
            expected_bytes.push_back('{b, last});
        end
    endtask

    task automatic write_escape_set(input logic [2:0] set);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ESCAPE_SET_ADDR;
        pwdata <= DATA_W'(set);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        escape_set_model = set;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Drains every outstanding byte, then waits out the pipeline with margin.
    task automatic wait_until_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_byte();
        logic [7:0] b;
        case ($urandom_range(3))
            0, 1: b = 8'($urandom_range(255));
            2: b = 8'($urandom_range(8'h7e, 8'h20));
            default: begin
                case ($urandom_range(6))
                    0: b = 8'h00;
                    1: b = 8'h1f;
                    2: b = 8'h20;
                    3: b = 8'h25;
                    4: b = 8'h7f;
                    5: b = 8'h80;
                    default: b = 8'hff;
                endcase
            end
        endcase
        return b;
    endfunction

    always @(posedge i_clk) begin
        if (holds_served != hold_requests) begin
            holds_served = holds_served + 1;
            hold_left = LONG_HOLD;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        enc_byte_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_bytes.size() == 0) begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("Unexpected output item: byte %h last %b",
                             m_axis_tdata, m_axis_tlast);
                end
            end else begin
                want = expected_bytes.pop_front();
                if (m_axis_tdata !== want.data || m_axis_tlast !== want.last) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("Output item differs: expected byte %h last %b, got byte %h last %b",
                                 want.data, want.last, m_axis_tdata, m_axis_tlast);
                    end
                end
            end
        end
    end

    initial begin
        stim_row_t   row;
        int          n;
        logic [2:0]  chunk_set;
        logic        first_row;

        first_row = 1'b1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            row = DIRECTED[i];
            if (first_row || row.set != escape_set_model) begin
                wait_until_idle();
                write_escape_set(row.set);
                first_row = 1'b0;
            end
            n = row.n_fixed;
            if (n == 0) begin
                predict_encoding(row.data, row.last);
            end else begin
                for (int k = 0; k < n; k++) begin
                    expected_bytes.push_back('{row.fixed_bytes[23 - 8 * k -: 8],
                                               row.last && (k == n - 1)});
                end
            end
            send_byte(row.data, row.last);
        end

        for (int chunk = 0; chunk < 8; chunk++) begin
            wait_until_idle();
            if (chunk < 3) begin
                tx_idle_pct = 31;
                rx_idle_pct = 60;
            end else if (chunk < 6) begin
                tx_idle_pct = 60;
                rx_idle_pct = 31;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case (chunk)
                0: chunk_set = SET_URI;
                1: chunk_set = SET_MAIL_AUTH;
                2: chunk_set = SET_UNUSED;
                3: chunk_set = SET_COMPONENT;
                default: chunk_set = 3'($urandom_range(7));
            endcase
            write_escape_set(chunk_set);
            if (chunk == 6) begin
                hold_requests = hold_requests + 1;
            end
            for (int j = 0; j < 17; j++) begin
                row.data = pick_byte();
                row.last = ($urandom_range(5) == 0) || (j == 16);
                predict_encoding(row.data, row.last);
                send_byte(row.data, row.last);
            end
        end

        wait_until_idle();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("url_percent_encoder: match");
        end else begin
            $display("url_percent_encoder: mismatch");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/upe_pkg.sv
hdl/url_percent_encoder.sv
hdl/upe_checker.sv
sim/testbench.sv
